>>> src/gtrg_pkg.sv
// Shared widths, register indexes and word types for the run grouper.
package gtrg_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int POS_W           = 10;
    localparam int WIDTH_W         = 11;
    localparam int COUNT_W         = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 16;
    localparam int M_TDATA_W       = 32;
    localparam int MAX_GROUPS_DEF  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_INDEX = 2'd3;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } in_word_t;

    typedef struct packed {
        logic               has_group;
        logic [POS_W-1:0]   center;
        logic [WIDTH_W-1:0] width;
        logic [COUNT_W-1:0] group_count;
        logic               done_res;
    } result_t;

    typedef struct packed {
        logic valid;
        logic ready;
    } flow_t;

endpackage

>>> src/gap_tolerant_run_grouper_top.sv
// Top level of the gap tolerant run grouper.
//
//   channel   dir  handshake              content
//   s_axis    in   tvalid/tready          sample words, tlast marks profile end
//   m_axis    out  tvalid/tready          group reports and end-of-profile results
//   cfg       in   cfg_we                 threshold, max_gap, min_span, base_index
//
// One sample word per cycle unless the result register stalls; a word waits in
// the input register until the core takes it; any result is registered then.
// Reset clears all group state and configuration; the first word after reset
// starts a profile at base_index. A stalled result register holds the input
// register, and s_axis_tready drops once both are full.
module gap_tolerant_run_grouper_top
    import gtrg_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // [9:0] center, [20:10] width,
                                                  // [25:21] group_count, [31:26] zero
    output logic                  m_axis_tlast,   // done_res
    output logic                  m_axis_tuser,   // has_group
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    in_word_t in_word;
    in_word_t word;
    logic     word_valid;
    logic     take;
    logic     out_ready;
    flow_t    res_flow;
    result_t  res;
    result_t  out_res;

    assign in_word.sample = s_axis_tdata;
    assign in_word.last   = s_axis_tlast;

    gtrg_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    gtrg_core #(
        .MAX_GROUPS (MAX_GROUPS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .word_valid (word_valid),
        .word       (word),
        .out_ready  (out_ready),
        .take       (take),
        .res_flow   (res_flow),
        .res        (res)
    );

    gtrg_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_flow  (res_flow),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (m_axis_tvalid),
        .out_take  (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {(M_TDATA_W - POS_W - WIDTH_W - COUNT_W)'(0),
                           out_res.group_count, out_res.width, out_res.center};
    assign m_axis_tlast = out_res.done_res;
    assign m_axis_tuser = out_res.has_group;

endmodule

>>> src/gtrg_in_stage.sv
// Input register: holds one accepted sample word until the core takes it.
module gtrg_in_stage
    import gtrg_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_word_t in_word,
    input  logic     take,
    output logic     word_valid,
    output in_word_t word
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

>>> src/gtrg_core.sv
// Configuration registers, group tracking state and per-sample decision logic.
module gtrg_core
    import gtrg_pkg::*;
#(
    parameter int MAX_GROUPS = MAX_GROUPS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  word_valid,
    input  in_word_t              word,
    input  logic                  out_ready,
    output logic                  take,
    output flow_t                 res_flow,
    output result_t               res
);

    localparam int GRP_W = $clog2(MAX_GROUPS + 1);
    localparam int EXT_W = (GRP_W > COUNT_W) ? GRP_W : COUNT_W;

    logic signed [SAMPLE_W-1:0] threshold_reg;
    logic [POS_W-1:0]           max_gap_reg;
    logic [POS_W-1:0]           min_span_reg;
    logic [POS_W-1:0]           base_index_reg;

    logic             in_group_reg,    in_group_next;
    logic [POS_W-1:0] group_start_reg, group_start_next;
    logic [POS_W-1:0] last_hit_reg,    last_hit_next;
    logic [POS_W-1:0] position_reg,    position_next;
    logic [POS_W-1:0] gap_run_reg,     gap_run_next;
    logic [GRP_W-1:0] groups_reg,      groups_next;
    logic             prof_start_reg,  prof_start_next;

    logic             hit;
    logic             below_limit;
    logic             close_gap;
    logic             start;
    logic             open_mid;
    logic             close;
    logic             qualify;
    logic [POS_W-1:0] span;
    logic [GRP_W-1:0] groups_after;
    logic [EXT_W-1:0] groups_ext;

    assign take = word_valid && out_ready;

    always_comb
    begin
        position_next = prof_start_reg ? base_index_reg : position_reg + 1'b1;
        hit           = word.sample >= threshold_reg;
        below_limit   = groups_reg < GRP_W'(MAX_GROUPS);
        close_gap     = in_group_reg && !hit && (gap_run_reg >= max_gap_reg);
        start         = !in_group_reg && hit && below_limit;
        open_mid      = (in_group_reg && !close_gap) || start;

        group_start_next = start ? position_next : group_start_reg;
        last_hit_next    = ((in_group_reg && hit) || start) ? position_next : last_hit_reg;

        close   = close_gap || (word.last && open_mid);
        span    = last_hit_next - group_start_next;
        qualify = close && (span >= min_span_reg) && below_limit;

        groups_after = groups_reg + GRP_W'(qualify);
        groups_ext   = EXT_W'(groups_after);

        in_group_next   = open_mid && !close;
        prof_start_next = word.last;
        groups_next     = word.last ? '0 : groups_after;

        if (close || word.last || hit)
        begin
            gap_run_next = '0;
        end
        else if (in_group_reg)
        begin
            gap_run_next = gap_run_reg + 1'b1;
        end
        else
        begin
            gap_run_next = gap_run_reg;
        end

        res_flow.valid  = take && (qualify || word.last);
        res_flow.ready  = out_ready;
        res.has_group   = qualify;
        res.center      = qualify ? group_start_next + (span >> 1) : '0;
        res.width       = qualify ? {1'b0, span} + 1'b1 : '0;
        res.group_count = groups_ext[COUNT_W-1:0];
        res.done_res    = word.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            max_gap_reg    <= '0;
            min_span_reg   <= '0;
            base_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_THRESHOLD:  threshold_reg  <= cfg_data;
                REG_MAX_GAP:    max_gap_reg    <= cfg_data[POS_W-1:0];
                REG_MIN_SPAN:   min_span_reg   <= cfg_data[POS_W-1:0];
                REG_BASE_INDEX: base_index_reg <= cfg_data[POS_W-1:0];
                default:        threshold_reg  <= threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_group_reg    <= 1'b0;
            group_start_reg <= '0;
            last_hit_reg    <= '0;
            position_reg    <= '0;
            gap_run_reg     <= '0;
            groups_reg      <= '0;
            prof_start_reg  <= 1'b1;
        end
        else if (take)
        begin
            in_group_reg    <= in_group_next;
            group_start_reg <= group_start_next;
            last_hit_reg    <= last_hit_next;
            position_reg    <= position_next;
            gap_run_reg     <= gap_run_next;
            groups_reg      <= groups_next;
            prof_start_reg  <= prof_start_next;
        end
    end

endmodule

>>> src/gtrg_out_stage.sv
// Result register: holds one result word until the downstream side takes it.
module gtrg_out_stage
    import gtrg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  flow_t   res_flow,
    input  result_t res,
    output logic    out_ready,
    output logic    out_valid,
    input  logic    out_take,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_ready  = !valid_reg || out_take;
    assign valid_next = res_flow.valid || (valid_reg && !out_take);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_flow.valid && res_flow.ready)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> src/gtrg_checker.sv
// Port-level checks on the run grouper, bound to the top level.
module gtrg_checker
    import gtrg_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic                 m_axis_tlast,
    input logic                 m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_empty_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("result without a group is not an end-of-profile word");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[20:0] == 21'd0)
        else $error("result without a group carries center or width");

    a_group_width: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[20:10] != 11'd0
            && m_axis_tdata[25:21] != 5'd0 || m_axis_tvalid && m_axis_tuser
            && m_axis_tdata[20:10] != 11'd0)
        else $error("group report with zero width");

endmodule

bind gap_tolerant_run_grouper_top gtrg_checker u_gtrg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
